FILE: src/mrn_pkg.sv
// shared constants and types for the masked residual norms block
package mrn_pkg;

   localparam int MAX_DIM = 1024;
   localparam int CNT_W   = $clog2(MAX_DIM + 1);
   localparam int SIZE_W  = 11;
   localparam int DATA_W  = 32;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int MAG_W   = 31;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int ACC_W   = 64;
   localparam int COORD_W = 11;
   localparam int CSR_W   = 2;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef enum logic [CSR_W-1:0] {
      CSR_SIZE_X     = 2'd0,
      CSR_SIZE_Y     = 2'd1,
      CSR_SIZE_Z     = 2'd2,
      CSR_SCALE_COEF = 2'd3
   } csr_index_type;

   // effective grid sizes, already clamped to 1..MAX_DIM
   typedef struct packed {
      logic [CNT_W-1:0] sx;
      logic [CNT_W-1:0] sy;
      logic [CNT_W-1:0] sz;
   } size_type;

   // one queued cell with its coordinates and end-of-grid mark
   typedef struct packed {
      logic signed [DATA_W-1:0] divergence;
      logic                     cell_valid;
      logic [CNT_W-1:0]         x;
      logic [CNT_W-1:0]         y;
      logic [CNT_W-1:0]         z;
      logic                     last;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

FILE: src/mrn_channels.sv
// valid/ready channel interfaces for cell words and result words
interface mrn_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mrn_pkg::DATA_W-1:0]      divergence;
   logic                                   cell_valid;

   modport source (output valid, divergence, cell_valid, input ready);
   modport sink   (input valid, divergence, cell_valid, output ready);
endinterface

interface mrn_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [mrn_pkg::MAG_W-1:0]              max_abs;
   logic [mrn_pkg::ACC_W-1:0]              sum_squares;
   logic [mrn_pkg::COORD_W-1:0]            max_x;
   logic [mrn_pkg::COORD_W-1:0]            max_y;
   logic [mrn_pkg::COORD_W-1:0]            max_z;
   logic                                   saturated;

   modport source (output valid, max_abs, sum_squares, max_x, max_y, max_z, saturated,
                   input ready);
   modport sink   (input valid, max_abs, sum_squares, max_x, max_y, max_z, saturated,
                   output ready);
endinterface

FILE: src/mrn_queue.sv
// short register queue between the front and back parts
module mrn_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mrn_pkg::item_type         push_item,
   input  logic                      pop,
   output mrn_pkg::item_type         head_item,
   output mrn_pkg::queue_status_type status
);

   mrn_pkg::item_type                 entry_ff [mrn_pkg::QDEPTH];
   logic [mrn_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mrn_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mrn_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == mrn_pkg::QCNT_W'(mrn_pkg::QDEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == mrn_pkg::QPTR_W'(mrn_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mrn_pkg::QPTR_W'(mrn_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/mrn_front.sv
// front part: takes cell words, tracks grid coordinates, marks the last cell
module mrn_front (
   input  logic                      clock,
   input  logic                      reset,
   mrn_req_if.sink                   req_ch,
   input  mrn_pkg::size_type         sizes,
   input  mrn_pkg::queue_status_type q_status,
   output logic                      push,
   output mrn_pkg::item_type         push_item
);

   logic [mrn_pkg::CNT_W-1:0] cnt_x_ff, cnt_x_in;
   logic [mrn_pkg::CNT_W-1:0] cnt_y_ff, cnt_y_in;
   logic [mrn_pkg::CNT_W-1:0] cnt_z_ff, cnt_z_in;
   logic                      end_x, end_y, end_z, last;

   assign req_ch.ready = !q_status.full;
   assign push         = req_ch.valid && !q_status.full;

   // a counter at or past its size ends the axis
   assign end_x = (cnt_x_ff >= sizes.sx);
   assign end_y = (cnt_y_ff >= sizes.sy);
   assign end_z = (cnt_z_ff >= sizes.sz);
   assign last  = end_x && end_y && end_z;

   assign push_item.divergence = req_ch.divergence;
   assign push_item.cell_valid = req_ch.cell_valid;
   assign push_item.x          = cnt_x_ff;
   assign push_item.y          = cnt_y_ff;
   assign push_item.z          = cnt_z_ff;
   assign push_item.last       = last;

   always_comb begin
      cnt_x_in = cnt_x_ff;
      cnt_y_in = cnt_y_ff;
      cnt_z_in = cnt_z_ff;
      if (push) begin
         if (last) begin
            cnt_x_in = mrn_pkg::CNT_W'(1);
            cnt_y_in = mrn_pkg::CNT_W'(1);
            cnt_z_in = mrn_pkg::CNT_W'(1);
         end else if (end_x) begin
            cnt_x_in = mrn_pkg::CNT_W'(1);
            if (end_y) begin
               cnt_y_in = mrn_pkg::CNT_W'(1);
               cnt_z_in = cnt_z_ff + 1'b1;
            end else begin
               cnt_y_in = cnt_y_ff + 1'b1;
            end
         end else begin
            cnt_x_in = cnt_x_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_x_ff <= mrn_pkg::CNT_W'(1);
         cnt_y_ff <= mrn_pkg::CNT_W'(1);
         cnt_z_ff <= mrn_pkg::CNT_W'(1);
      end else begin
         cnt_x_ff <= cnt_x_in;
         cnt_y_ff <= cnt_y_in;
         cnt_z_ff <= cnt_z_in;
      end
   end

endmodule

FILE: src/mrn_back.sv
// back part: scale, saturate, square, accumulate and hold the result word
module mrn_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [mrn_pkg::DATA_W-1:0] scale_coef,
   input  mrn_pkg::item_type            head_item,
   input  mrn_pkg::queue_status_type    q_status,
   output logic                         pop,
   mrn_rsp_if.source                    rsp_ch
);

   logic advance;

   // stage 1: product
   logic                                v1_ff;
   logic signed [mrn_pkg::PROD_W-1:0]   prod1_ff;
   logic                                cval1_ff, last1_ff;
   logic [mrn_pkg::CNT_W-1:0]           x1_ff, y1_ff, z1_ff;

   // stage 2: magnitude
   logic                                v2_ff, sat2_ff, last2_ff;
   logic [mrn_pkg::MAG_W-1:0]           mag2_ff, mag2_in;
   logic                                sat2_in;
   logic [mrn_pkg::CNT_W-1:0]           x2_ff, y2_ff, z2_ff;

   // stage 3: square
   logic                                v3_ff, sat3_ff, last3_ff;
   logic [mrn_pkg::MAG_W-1:0]           mag3_ff;
   logic [mrn_pkg::SQ_W-1:0]            sq3_ff;
   logic [mrn_pkg::CNT_W-1:0]           x3_ff, y3_ff, z3_ff;

   // accumulation state
   logic [mrn_pkg::ACC_W-1:0]           acc_ff, acc_in;
   logic [mrn_pkg::MAG_W-1:0]           max_ff, max_in;
   logic [mrn_pkg::CNT_W-1:0]           bx_ff, by_ff, bz_ff, bx_in, by_in, bz_in;
   logic                                sat_ff, sat_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mrn_pkg::MAG_W-1:0]           rsp_max_ff;
   logic [mrn_pkg::ACC_W-1:0]           rsp_sum_ff;
   logic [mrn_pkg::COORD_W-1:0]         rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                                rsp_sat_ff;

   logic signed [mrn_pkg::PROD_W-17:0]  q_full;
   logic [mrn_pkg::DATA_W-1:0]          q_word;
   logic                                q_ovf;
   logic [mrn_pkg::ACC_W:0]             acc_sum;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign pop     = advance && !q_status.empty;

   // floor shift by 16, then range and magnitude saturation
   assign q_full = prod1_ff[mrn_pkg::PROD_W-1:16];
   assign q_word = q_full[mrn_pkg::DATA_W-1:0];
   assign q_ovf  = !((&q_full[mrn_pkg::PROD_W-17:mrn_pkg::DATA_W-1]) ||
                     !(|q_full[mrn_pkg::PROD_W-17:mrn_pkg::DATA_W-1]));

   always_comb begin
      mag2_in = '0;
      sat2_in = 1'b0;
      if (cval1_ff) begin
         if (q_ovf || q_word == {1'b1, {(mrn_pkg::DATA_W-1){1'b0}}}) begin
            mag2_in = '1;
            sat2_in = 1'b1;
         end else if (q_word[mrn_pkg::DATA_W-1]) begin
            mag2_in = mrn_pkg::MAG_W'(~q_word + 1'b1);
         end else begin
            mag2_in = q_word[mrn_pkg::MAG_W-1:0];
         end
      end
   end

   assign acc_sum = {1'b0, acc_ff} + (mrn_pkg::ACC_W+1)'(sq3_ff);

   always_comb begin
      acc_in = acc_sum[mrn_pkg::ACC_W] ? '1 : acc_sum[mrn_pkg::ACC_W-1:0];
      sat_in = sat_ff || sat3_ff || acc_sum[mrn_pkg::ACC_W];
      max_in = max_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      bz_in  = bz_ff;
      if (mag3_ff > max_ff) begin
         max_in = mag3_ff;
         bx_in  = x3_ff;
         by_in  = y3_ff;
         bz_in  = z3_ff;
      end
   end

   // result word held until taken; a new one may load as the old one leaves
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (advance && v3_ff && last3_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         max_ff       <= '0;
         bx_ff        <= '0;
         by_ff        <= '0;
         bz_ff        <= '0;
         sat_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            v1_ff <= pop;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            if (v3_ff) begin
               if (last3_ff) begin
                  acc_ff       <= '0;
                  max_ff       <= '0;
                  bx_ff        <= '0;
                  by_ff        <= '0;
                  bz_ff        <= '0;
                  sat_ff       <= 1'b0;
               end else begin
                  acc_ff <= acc_in;
                  max_ff <= max_in;
                  bx_ff  <= bx_in;
                  by_ff  <= by_in;
                  bz_ff  <= bz_in;
                  sat_ff <= sat_in;
               end
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         prod1_ff <= $signed(head_item.divergence) * scale_coef;
         cval1_ff <= head_item.cell_valid;
         last1_ff <= head_item.last;
         x1_ff    <= head_item.x;
         y1_ff    <= head_item.y;
         z1_ff    <= head_item.z;

         mag2_ff  <= mag2_in;
         sat2_ff  <= sat2_in;
         last2_ff <= last1_ff;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         z2_ff    <= z1_ff;

         sq3_ff   <= mag2_ff * mag2_ff;
         mag3_ff  <= mag2_ff;
         sat3_ff  <= sat2_ff;
         last3_ff <= last2_ff;
         x3_ff    <= x2_ff;
         y3_ff    <= y2_ff;
         z3_ff    <= z2_ff;

         if (v3_ff && last3_ff) begin
            rsp_max_ff <= max_in;
            rsp_sum_ff <= acc_in;
            rsp_x_ff   <= mrn_pkg::COORD_W'(bx_in);
            rsp_y_ff   <= mrn_pkg::COORD_W'(by_in);
            rsp_z_ff   <= mrn_pkg::COORD_W'(bz_in);
            rsp_sat_ff <= sat_in;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.max_abs     = rsp_max_ff;
   assign rsp_ch.sum_squares = rsp_sum_ff;
   assign rsp_ch.max_x       = rsp_x_ff;
   assign rsp_ch.max_y       = rsp_y_ff;
   assign rsp_ch.max_z       = rsp_z_ff;
   assign rsp_ch.saturated   = rsp_sat_ff;

endmodule

FILE: src/masked_residual_norms.sv
// masked residual norms: top level with configuration registers
// throughput: one cell word per cycle while no result word waits to be taken
// a result word is registered after the last cell word of a grid passes the queue slot,
// product, magnitude and square registers and is accumulated into the result register
// the pipeline stalls only while a result word waits to be taken; the queue holds 4 cells
// reset: sizes 1,1,1 and coefficient 1.0, counters at 1, sums cleared; no clearing pass
module masked_residual_norms (
   input  logic                           clock,
   input  logic                           reset,
   mrn_req_if.sink                        req_ch,
   mrn_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [mrn_pkg::CSR_W-1:0]      csr_index,
   input  logic [mrn_pkg::DATA_W-1:0]     csr_wdata
);

   // configuration registers
   logic [mrn_pkg::SIZE_W-1:0]         size_x_ff, size_y_ff, size_z_ff;
   logic signed [mrn_pkg::DATA_W-1:0]  coef_ff;

   mrn_pkg::size_type                  sizes;
   mrn_pkg::queue_status_type          q_status;
   mrn_pkg::item_type                  push_item, head_item;
   logic                               push, pop;

   // clamp a size register into 1..MAX_DIM
   function automatic logic [mrn_pkg::CNT_W-1:0] eff_size(
      input logic [mrn_pkg::SIZE_W-1:0] s
   );
      logic [31:0] wide;
      wide = 32'(s);
      if (wide == 32'd0) begin
         return mrn_pkg::CNT_W'(1);
      end else if (wide > 32'(mrn_pkg::MAX_DIM)) begin
         return mrn_pkg::CNT_W'(mrn_pkg::MAX_DIM);
      end
      return mrn_pkg::CNT_W'(wide);
   endfunction

   assign sizes.sx = eff_size(size_x_ff);
   assign sizes.sy = eff_size(size_y_ff);
   assign sizes.sz = eff_size(size_z_ff);

   // register writes, meant for an idle block
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= mrn_pkg::SIZE_W'(1);
         size_y_ff <= mrn_pkg::SIZE_W'(1);
         size_z_ff <= mrn_pkg::SIZE_W'(1);
         coef_ff   <= mrn_pkg::DATA_W'(65536);
      end else if (csr_wr_en) begin
         case (mrn_pkg::csr_index_type'(csr_index))
            mrn_pkg::CSR_SIZE_X:     size_x_ff <= csr_wdata[mrn_pkg::SIZE_W-1:0];
            mrn_pkg::CSR_SIZE_Y:     size_y_ff <= csr_wdata[mrn_pkg::SIZE_W-1:0];
            mrn_pkg::CSR_SIZE_Z:     size_z_ff <= csr_wdata[mrn_pkg::SIZE_W-1:0];
            mrn_pkg::CSR_SCALE_COEF: coef_ff   <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // front: coordinates and end-of-grid mark
   mrn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .sizes     (sizes),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   // decoupling queue
   mrn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // back: arithmetic pipeline and result register
   mrn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .scale_coef (coef_ff),
      .head_item  (head_item),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

`ifndef SYNTH
   // no result word straight out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result word valid right after reset");

   // a zero maximum means no cell won, so coordinates stay at zero
   a_zero_max_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.max_abs == '0) |->
         (rsp_ch.max_x == '0 && rsp_ch.max_y == '0 && rsp_ch.max_z == '0))
      else $error("coordinates set without a nonzero maximum");

   // a zero maximum means every square was zero and nothing saturated
   a_zero_max_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.max_abs == '0) |->
         (rsp_ch.sum_squares == '0 && !rsp_ch.saturated))
      else $error("sum or saturation without a nonzero maximum");
`endif

endmodule
